/* hdl/udm_pkg.sv */
// shared types and constants for the unsigned divisor magic number block
package udm_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned P_W    = 7;
	localparam int unsigned SHF_W  = 6;

	localparam logic [WORD_W-1:0] TWO31       = 32'h8000_0000;
	localparam logic [WORD_W-1:0] TWO31_M1    = 32'h7FFF_FFFF;
	localparam logic [CNT_W-1:0]  DIV_STEPS   = 6'd32;
	localparam logic [P_W-1:0]    P_START     = 7'd31;
	localparam logic [P_W-1:0]    P_LIMIT     = 7'd64;
	localparam logic [P_W-1:0]    P_BIAS      = 7'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NC,
		ST_Q1,
		ST_Q2,
		ST_LOOP,
		ST_DONE
	} state_t;

endpackage

/* hdl/udm_div.sv */
// restoring divider, one quotient bit per cycle, shared by all seed divisions
module udm_div
	import udm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient,
	output logic [WORD_W-1:0] remainder
);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   rem_sub;
	logic              fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[WORD_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of the top of quo_q as quotient bits enter below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= rem_sub[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/unsigned_divisor_magic_number.sv */
// top level: magic multiplier, post-shift and add flag for a constant unsigned divisor
// sequence: three seed divisions on one shared divider, 1 to 33 doubling steps and
//   a result load before m_tvalid; divisors below 2 go straight to the result load
// flow: s_tready stays low until the result is registered, so a new divisor is not taken
//   while one is in work; a result held on m_tready does not block the next word
// reset: arst_n clears the sequencer, the divider counter and the output valid; datapath registers are not reset
module unsigned_divisor_magic_number
	import udm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // divisor[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // valid_res[0], multiplier[32:1], shift_amt[38:33], add_form[39]
);

	state_t            state_q, state_nx;
	logic              start_q, start_nx;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;
	logic [WORD_W-1:0] div_rem;
	logic [WORD_W-1:0] div_dividend;
	logic [WORD_W-1:0] div_divisor;

	logic [WORD_W-1:0] d_q;
	logic [WORD_W-1:0] nc_q;
	logic [WORD_W-1:0] q1_q, r1_q, q2_q, r2_q;
	logic [P_W-1:0]    p_q;
	logic              add_q;
	logic              ok_q;

	logic              out_vld_q;
	logic              res_vld_q;
	logic [WORD_W-1:0] res_mult_q;
	logic [SHF_W-1:0]  res_shift_q;
	logic              res_add_q;

	logic [P_W-1:0]    p_nx;
	logic [WORD_W-1:0] q1_nx, r1_nx, q2_nx, r2_nx, delta;
	logic              add_nx;
	logic              go_on;
	logic [P_W-1:0]    shift_full;
	logic [SHF_W-1:0]  shift_fin;
	logic              accept;
	logic              load_out;

	udm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// operands for the division that starts in the current state
	always_comb begin
		case (state_q)
			ST_NC: begin
				div_dividend = '0 - d_q;
				div_divisor  = d_q;
			end
			ST_Q1: begin
				div_dividend = TWO31;
				div_divisor  = nc_q;
			end
			ST_Q2: begin
				div_dividend = TWO31_M1;
				div_divisor  = d_q;
			end
			default: begin
				div_dividend = '0 - d_q;
				div_divisor  = d_q;
			end
		endcase
	end

	// one doubling step of both quotient/remainder pairs
	always_comb begin
		p_nx = p_q + 1'b1;
		if ({1'b0, r1_q} >= ({1'b0, nc_q} - {1'b0, r1_q})) begin
			q1_nx = {q1_q[WORD_W-2:0], 1'b1};
			r1_nx = {r1_q[WORD_W-2:0], 1'b0} - nc_q;
		end else begin
			q1_nx = {q1_q[WORD_W-2:0], 1'b0};
			r1_nx = {r1_q[WORD_W-2:0], 1'b0};
		end
		add_nx = add_q;
		if (({1'b0, r2_q} + 1'b1) >= ({1'b0, d_q} - {1'b0, r2_q})) begin
			if (q2_q >= TWO31_M1) begin
				add_nx = 1'b1;
			end
			q2_nx = {q2_q[WORD_W-2:0], 1'b1};
			r2_nx = {r2_q[WORD_W-2:0], 1'b1} - d_q;
		end else begin
			if (q2_q[WORD_W-1]) begin
				add_nx = 1'b1;
			end
			q2_nx = {q2_q[WORD_W-2:0], 1'b0};
			r2_nx = {r2_q[WORD_W-2:0], 1'b1};
		end
		delta = d_q - 1'b1 - r2_nx;
		go_on = (p_nx < P_LIMIT) &&
			((q1_nx < delta) || ((q1_nx == delta) && (r1_nx == '0)));
	end

	always_comb begin
		shift_full = p_q - P_BIAS;
		if (add_q && (shift_full != '0)) begin
			shift_full = shift_full - 1'b1;
		end
		shift_fin = shift_full[SHF_W-1:0];
	end

	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == ST_DONE) && (!out_vld_q || m_tready);

	// sequencer
	always_comb begin
		state_nx = state_q;
		start_nx = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tdata < WORD_W'(2)) begin
						state_nx = ST_DONE;
					end else begin
						state_nx = ST_NC;
						start_nx = 1'b1;
					end
				end
			end
			ST_NC: begin
				if (div_done) begin
					state_nx = ST_Q1;
					start_nx = 1'b1;
				end
			end
			ST_Q1: begin
				if (div_done) begin
					state_nx = ST_Q2;
					start_nx = 1'b1;
				end
			end
			ST_Q2: begin
				if (div_done) begin
					state_nx = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (!go_on) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			start_q <= start_nx;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= s_tdata;
			ok_q  <= s_tdata >= WORD_W'(2);
			p_q   <= P_START;
			add_q <= 1'b0;
		end
		if (div_done) begin
			case (state_q)
				ST_NC: begin
					nc_q <= ~div_rem;
				end
				ST_Q1: begin
					q1_q <= div_quo;
					r1_q <= div_rem;
				end
				ST_Q2: begin
					q2_q <= div_quo;
					r2_q <= div_rem;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_LOOP) begin
			p_q   <= p_nx;
			q1_q  <= q1_nx;
			r1_q  <= r1_nx;
			q2_q  <= q2_nx;
			r2_q  <= r2_nx;
			add_q <= add_nx;
		end
		if (load_out) begin
			res_vld_q   <= ok_q;
			res_mult_q  <= ok_q ? q2_q + 1'b1 : '0;
			res_shift_q <= ok_q ? shift_fin : '0;
			res_add_q   <= ok_q && add_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {res_add_q, res_shift_q, res_mult_q, res_vld_q};

endmodule

/* test/tb.sv */
// testbench for the unsigned divisor magic number block: random divisors, checked words
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned DRAIN_WAIT = 160;
	localparam int unsigned MAX_PRINTS = 40;
	localparam int unsigned N_RANDOM   = 950;

	localparam logic [63:0] MASK32  = 64'hFFFF_FFFF;
	localparam logic [63:0] POW31   = 64'h8000_0000;

	// receiver stall patterns
	localparam int unsigned RDY_ON   = 0;
	localparam int unsigned RDY_OFF  = 1;
	localparam int unsigned RDY_RAND = 2;

	typedef struct {
		logic [31:0] divisor;
		logic        valid_res;
		logic [31:0] multiplier;
		logic [5:0]  shift_amt;
		logic        add_form;
	} magic_t;

	typedef struct {
		logic [31:0] divisor;
		bit          drain_first;
	} pending_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // divisor[31:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // valid_res[0], multiplier[32:1], shift_amt[38:33], add_form[39]

	pending_t    divisor_q[$];
	magic_t      magic_due_q[$];

	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_rejected = 0;
	int unsigned n_add = 0;
	int unsigned max_shift = 0;
	int unsigned idle_cycles = 0;

	unsigned_divisor_magic_number u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// multiplier, post-shift and add flag for division by a constant
	function automatic magic_t calc_magic(input logic [31:0] dv);
		logic [63:0] d, nc, q1, r1, q2, r2, delta;
		int unsigned p;
		int unsigned shift;
		bit          add;
		bit          done;
		magic_t      res;
		res.divisor    = dv;
		res.valid_res  = 1'b0;
		res.multiplier = '0;
		res.shift_amt  = '0;
		res.add_form   = 1'b0;
		d = {32'd0, dv};
		if (d < 64'd2)
			return res;
		nc = MASK32 - (((MASK32 + 64'd1) - d) % d);
		q1 = POW31 / nc;
		r1 = POW31 % nc;
		q2 = (POW31 - 64'd1) / d;
		r2 = (POW31 - 64'd1) % d;
		p = 31;
		add = 1'b0;
		do begin
			p++;
			if (r1 >= nc - r1) begin
				q1 = ((q1 << 1) + 64'd1) & MASK32;
				r1 = ((r1 << 1) - nc) & MASK32;
			end else begin
				q1 = (q1 << 1) & MASK32;
				r1 = (r1 << 1) & MASK32;
			end
			if (r2 + 64'd1 >= d - r2) begin
				if (q2 >= POW31 - 64'd1)
					add = 1'b1;
				q2 = ((q2 << 1) + 64'd1) & MASK32;
				r2 = ((r2 << 1) + 64'd1 - d) & MASK32;
			end else begin
				if (q2 >= POW31)
					add = 1'b1;
				q2 = (q2 << 1) & MASK32;
				r2 = ((r2 << 1) + 64'd1) & MASK32;
			end
			delta = (d - 64'd1 - r2) & MASK32;
			done = !(p < 64 && (q1 < delta || (q1 == delta && r1 == 64'd0)));
		end while (!done);
		shift = p - 32;
		// add form runs one extra shift inside the fixup, so take it back here
		if (add && shift > 0)
			shift--;
		res.valid_res  = 1'b1;
		res.multiplier = 32'((q2 + 64'd1) & MASK32);
		res.shift_amt  = 6'(shift);
		res.add_form   = add;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] dv,
			input logic [63:0] got, input logic [63:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch %s for divisor 0x%08h: got 0x%0h, want 0x%0h", what, dv, got, want);
	endtask

	task automatic add_divisor(input logic [31:0] dv, input bit drain);
		pending_t it;
		it.divisor     = dv;
		it.drain_first = drain;
		divisor_q.push_back(it);
	endtask

	// driver: bursts of words with random gaps between them
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		bit       accepted;
		bit       drive_next;
		pending_t nxt;
		accepted = s_tvalid && s_tready;
		if (accepted)
			magic_due_q.push_back(calc_magic(s_tdata));
		if (arst_n && !(s_tvalid && !accepted)) begin
			drive_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (divisor_q.size() > 0) begin
				nxt = divisor_q[0];
				// hold off until the block has drained every word in flight
				if (!nxt.drain_first || (magic_due_q.size() == 0 && !accepted))
					drive_next = 1'b1;
			end
			if (drive_next) begin
				void'(divisor_q.pop_front());
				s_tdata <= nxt.divisor;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : 0;
				end
			end
			s_tvalid <= drive_next;
		end
	end

	// monitor: checks each result word, receiver stalls on its own pattern
	int unsigned rdy_mode = RDY_ON;
	int unsigned rdy_left = 0;

	always @(posedge clk) begin
		magic_t want;
		bit     rdy_next;
		if (m_tvalid && m_tready && arst_n) begin
			if (magic_due_q.size() == 0) begin
				report_mismatch("unexpected word", 32'd0, {24'd0, m_tdata}, 64'd0);
			end else begin
				want = magic_due_q.pop_front();
				n_checked++;
				if (!want.valid_res)
					n_rejected++;
				if (want.add_form)
					n_add++;
				if (32'(want.shift_amt) > max_shift)
					max_shift = 32'(want.shift_amt);
				if (m_tdata[0] !== want.valid_res)
					report_mismatch("valid_res", want.divisor, 64'(m_tdata[0]),
						64'(want.valid_res));
				if (m_tdata[32:1] !== want.multiplier)
					report_mismatch("multiplier", want.divisor, 64'(m_tdata[32:1]),
						64'(want.multiplier));
				if (m_tdata[38:33] !== want.shift_amt)
					report_mismatch("shift_amt", want.divisor, 64'(m_tdata[38:33]),
						64'(want.shift_amt));
				if (m_tdata[39] !== want.add_form)
					report_mismatch("add_form", want.divisor, 64'(m_tdata[39]),
						64'(want.add_form));
			end
		end
		if (rdy_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					rdy_mode = RDY_ON;
					rdy_left = $urandom_range(1, 400);
				end
				4, 5, 6: begin
					rdy_mode = RDY_OFF;
					rdy_left = $urandom_range(1, 300);
				end
				default: begin
					rdy_mode = RDY_RAND;
					rdy_left = $urandom_range(1, 100);
				end
			endcase
		end else begin
			rdy_left--;
		end
		case (rdy_mode)
			RDY_ON:  rdy_next = 1'b1;
			RDY_OFF: rdy_next = 1'b0;
			default: rdy_next = 1'($urandom_range(0, 1));
		endcase
		m_tready <= rdy_next;
	end

	// watchdog on cycles in which no word moves on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [31:0] v;
		int unsigned k;
		// directed: rejected divisors, powers of two, add-form cases, field extremes
		add_divisor(32'd0, 1'b0);
		add_divisor(32'd1, 1'b0);
		add_divisor(32'd2, 1'b0);
		add_divisor(32'd3, 1'b0);
		add_divisor(32'd5, 1'b0);
		add_divisor(32'd6, 1'b0);
		add_divisor(32'd7, 1'b0);
		add_divisor(32'd10, 1'b0);
		add_divisor(32'd14, 1'b0);
		add_divisor(32'd641, 1'b0);
		add_divisor(32'd1000, 1'b0);
		add_divisor(32'd6700417, 1'b0);
		add_divisor(32'h0001_0000, 1'b0);
		add_divisor(32'h7FFF_FFFF, 1'b0);
		add_divisor(32'h8000_0000, 1'b0);
		add_divisor(32'h8000_0001, 1'b0);
		add_divisor(32'hAAAA_AAAA, 1'b0);
		add_divisor(32'h5555_5555, 1'b0);
		add_divisor(32'hFFFF_FFFE, 1'b0);
		add_divisor(32'hFFFF_FFFF, 1'b0);
		for (int i = 0; i < N_RANDOM; i++) begin
			k = $urandom_range(0, 31);
			case ($urandom_range(0, 7))
				0, 1: v = $urandom;
				2: v = $urandom_range(0, 64);
				3: v = $urandom_range(0, 1023);
				4: v = (32'd1 << k) + 32'($signed($urandom_range(0, 2)) - 1);
				5: v = 32'hFFFF_FFFF - $urandom_range(0, 300);
				6: v = $urandom >> k;
				default: v = ($urandom_range(1, 15) | 32'd1) << $urandom_range(0, 28);
			endcase
			add_divisor(v, (i % 237) == 0);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (divisor_q.size() > 0 || s_tvalid || magic_due_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (magic_due_q.size() != 0)
			report_mismatch("missing words", 32'd0, 64'd0, 64'(magic_due_q.size()));
		$display("checked %0d divisors: %0d rejected below two, %0d needing the add fixup",
			n_checked, n_rejected, n_add);
		$display("largest post-shift seen %0d, %0d mismatches", max_shift, n_errors);
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
